// ----- hw/rtl/keyword_token_classifier_top_defines.svh -----
// ----------------------------------------------------------------------------
// Keyword token classifier assertion macros
// Shared concurrent assertion forms, clocked on clk; one form is qualified by rst_n.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_CLASSIFIER_TOP_DEFINES_SVH
`define KEYWORD_TOKEN_CLASSIFIER_TOP_DEFINES_SVH

// Checked only while out of reset.
`define KTC_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ktc_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyword token classifier package
// Widths, hash constants, token kind codes and the fixed keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package ktc_pkg;

  localparam int CHAR_W          = 8;
  localparam int HASH_W          = 16;
  localparam int KIND_W          = 4;
  localparam int TABLE_SLOTS     = 32;
  localparam int MAX_KEYWORD_LEN = 4;
  localparam int KW_COUNT        = 10;
  localparam int KW_CHARS        = 4;

  // Length counter saturates at MAX_KEYWORD_LEN + 1.
  localparam int CNT_W = $clog2(MAX_KEYWORD_LEN + 2);
  localparam int IDX_W = $clog2(MAX_KEYWORD_LEN);

  localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(27);
  localparam logic [HASH_W-1:0] SLOT_MASK = HASH_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_KEYWORD_LEN);

  typedef enum logic [KIND_W-1:0] {
    KIND_INVALID = 4'd0,
    KIND_ADD     = 4'd1,
    KIND_SUB     = 4'd2,
    KIND_MUL     = 4'd3,
    KIND_DIV     = 4'd4,
    KIND_SWAP    = 4'd5,
    KIND_ROT     = 4'd6,
    KIND_POP     = 4'd7,
    KIND_DUP     = 4'd8,
    KIND_DROP    = 4'd9,
    KIND_NIP     = 4'd10
  } kind_t;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t KW_TEXT [KW_COUNT][KW_CHARS] = '{
    '{8'h2B, 8'h00, 8'h00, 8'h00},  // +
    '{8'h2D, 8'h00, 8'h00, 8'h00},  // -
    '{8'h2A, 8'h00, 8'h00, 8'h00},  // *
    '{8'h2F, 8'h00, 8'h00, 8'h00},  // /
    '{"s", "w", "a", "p"},
    '{"r", "o", "t", 8'h00},
    '{"p", "o", "p", 8'h00},
    '{"d", "u", "p", 8'h00},
    '{"d", "r", "o", "p"},
    '{"n", "i", "p", 8'h00}
  };

  localparam int KW_LEN [KW_COUNT] = '{1, 1, 1, 1, 4, 3, 3, 3, 4, 3};

  localparam kind_t KW_KIND [KW_COUNT] = '{
    KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_SWAP,
    KIND_ROT, KIND_POP, KIND_DUP, KIND_DROP, KIND_NIP
  };

  // One hash step: h * 31 + c, wrapping at the hash width.
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input char_t c);
    hash_step = (h << 5) - h + HASH_W'(c);
  endfunction

  // Full hash of keyword k; constant-folded since k is always a loop constant.
  function automatic logic [HASH_W-1:0] kw_hash(input int k);
    logic [HASH_W-1:0] h;
    h = HASH_SEED;
    for (int i = 0; i < KW_CHARS; i++) begin
      if (i < KW_LEN[k]) begin
        h = hash_step(h, KW_TEXT[k][i]);
      end
    end
    kw_hash = h;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ktc_stream_if.sv -----
// ----------------------------------------------------------------------------
// Keyword token classifier channels
// Valid/ready interfaces for the character stream and the token kind results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ktc_char_if;
  import ktc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              token_end;

  modport source (output valid, output char_code, output token_end, input ready);
  modport sink   (input valid, input char_code, input token_end, output ready);
endinterface

interface ktc_kind_if;
  import ktc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;

  modport source (output valid, output token_kind, input ready);
  modport sink   (input valid, input token_kind, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/keyword_token_classifier_top.sv -----
// ----------------------------------------------------------------------------
// Keyword token classifier
// Hashes a token one character per beat and looks it up in a fixed keyword
// table, giving one token kind beat per token.
// ----------------------------------------------------------------------------
//  channel  | direction | beat payload            | beats
//  in_ch    | sink      | char_code, token_end    | one per character
//  out_ch   | source    | token_kind              | one per token
//
// An accepted character is held in an input register; the hash step, length
// count and keyword compare then run combinationally from it into the token
// state and result registers, so one character can be taken every cycle
// unless a token end is waiting on a full result register.
// Reset is synchronous, active low, and leaves both registers empty.
// A stalled result holds back only a character that ends a token, and those behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_token_classifier_top (
  input  wire logic clk,
  input  wire logic rst_n,
  ktc_char_if.sink  in_ch,
  ktc_kind_if.source out_ch
);
  import ktc_pkg::*;

`include "keyword_token_classifier_top_defines.svh"

  // Input register
  logic              s1_valid_r;
  char_t             s1_char_r;
  logic              s1_end_r;
  logic              s1_adv;

  // Token state
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  char_t             store_r   [MAX_KEYWORD_LEN];
  char_t             store_nxt [MAX_KEYWORD_LEN];

  // Result register
  logic              out_valid_r;
  kind_t             out_kind_r;
  kind_t             kind_nxt;

  // A character moves on unless it ends a token and the result slot is full and not being taken.
  assign s1_adv      = s1_valid_r && (!s1_end_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_code;
      s1_end_r  <= in_ch.token_end;
    end
  end

  // Hash step, length count and character store including this character.
  always_comb begin
    hash_nxt  = hash_step(hash_r, s1_char_r);
    store_nxt = store_r;
    if (cnt_r < CNT_MAX) begin
      store_nxt[cnt_r[IDX_W-1:0]] = s1_char_r;
    end
    cnt_nxt = (cnt_r <= CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
  end

  // The lowest keyword whose hash lands in the slot owns it; the token must
  // then match that keyword in length and in every character.
  always_comb begin
    logic found;
    logic hit;
    found    = 1'b0;
    hit      = 1'b0;
    kind_nxt = KIND_INVALID;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!found && ((hash_nxt & SLOT_MASK) == (kw_hash(k) & SLOT_MASK))) begin
        found = 1'b1;
        hit   = (cnt_nxt == CNT_W'(KW_LEN[k]));
        for (int i = 0; i < KW_CHARS; i++) begin
          if (i < KW_LEN[k] && store_nxt[i] != KW_TEXT[k][i]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          kind_nxt = KW_KIND[k];
        end
      end
    end
  end

  // Token state returns to its start value after the last character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_SEED;
      cnt_r  <= '0;
    end else if (s1_adv) begin
      hash_r <= s1_end_r ? HASH_SEED : hash_nxt;
      cnt_r  <= s1_end_r ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      store_r <= store_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_end_r) begin
      out_kind_r <= kind_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.token_kind = out_kind_r;

  // Checks
  `KTC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "registers not empty after reset")
  `KTC_ASSERT_ON(a_end_gives_result, s1_adv && s1_end_r |=> out_valid_r, "token end gave no result")
  `KTC_ASSERT_ON(a_state_cleared, s1_adv && s1_end_r |=> hash_r == HASH_SEED && cnt_r == '0, "token state not cleared")
  `KTC_ASSERT_ON(a_cnt_bound, cnt_r <= CNT_MAX + CNT_W'(1), "length counter past saturation")
  `KTC_ASSERT_ON(a_kind_range, out_valid_r |-> out_kind_r <= KIND_NIP, "token kind out of range")

endmodule

`default_nettype wire

// ----- tb/sv/keyword_kind_checker.sv -----
// ----------------------------------------------------------------------------
// Keyword token classifier checker
// Watches the character and token kind channels, works out the kind each
// token should get, and compares it with every result beat in order.
// ----------------------------------------------------------------------------
module keyword_kind_checker
  import ktc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ktc_char_if  char_mon,
  ktc_kind_if  kind_mon,
  output int   mismatches,
  output int   pending,
  output int   tokens_checked,
  output int   keyword_hits
);

  // Running state of the token being received.
  logic [HASH_W-1:0] hash_run;
  char_t             token_chars [MAX_KEYWORD_LEN];
  int                token_len;
  kind_t             expected_kinds [$];

  // The fixed keyword list, lowest code first. Text is right-justified,
  // so the first character sits in the highest used byte.
  function automatic void keyword_entry(input int k, output logic [31:0] text,
                                        output int len, output kind_t kind);
    case (k)
      0: begin text = "+";    len = 1; kind = KIND_ADD;  end
      1: begin text = "-";    len = 1; kind = KIND_SUB;  end
      2: begin text = "*";    len = 1; kind = KIND_MUL;  end
      3: begin text = "/";    len = 1; kind = KIND_DIV;  end
      4: begin text = "swap"; len = 4; kind = KIND_SWAP; end
      5: begin text = "rot";  len = 3; kind = KIND_ROT;  end
      6: begin text = "pop";  len = 3; kind = KIND_POP;  end
      7: begin text = "dup";  len = 3; kind = KIND_DUP;  end
      8: begin text = "drop"; len = 4; kind = KIND_DROP; end
      default: begin text = "nip"; len = 3; kind = KIND_NIP; end
    endcase
  endfunction

  // Table slot that keyword k hashes to.
  function automatic logic [HASH_W-1:0] keyword_slot(input int k);
    logic [31:0]       text;
    int                len;
    kind_t             kind;
    logic [HASH_W-1:0] h;
    keyword_entry(k, text, len, kind);
    h = HASH_SEED;
    for (int i = 0; i < len; i++) begin
      h = h * HASH_W'(31) + HASH_W'(text[8*(len-1-i) +: 8]);
    end
    return h & HASH_W'(TABLE_SLOTS - 1);
  endfunction

  // Kind of the token just finished. The lowest code that maps to the slot
  // owns it; the token must then equal that keyword exactly.
  function automatic kind_t classify_token();
    logic [HASH_W-1:0] slot;
    logic [31:0]       text;
    int                kw_len;
    kind_t             kind;
    slot = hash_run & HASH_W'(TABLE_SLOTS - 1);
    for (int k = 0; k < KW_COUNT; k++) begin
      if (keyword_slot(k) == slot) begin
        keyword_entry(k, text, kw_len, kind);
        if (token_len != kw_len || token_len > MAX_KEYWORD_LEN) return KIND_INVALID;
        for (int i = 0; i < token_len; i++) begin
          if (token_chars[i] != text[8*(kw_len-1-i) +: 8]) return KIND_INVALID;
        end
        return kind;
      end
    end
    return KIND_INVALID;
  endfunction

  always @(posedge clk) begin : monitor
    kind_t want;
    if (!rst_n) begin
      hash_run       = HASH_SEED;
      token_len      = 0;
      mismatches     = 0;
      tokens_checked = 0;
      keyword_hits   = 0;
      expected_kinds.delete();
    end else begin
      // Result beats are compared against the oldest expected kind.
      if (kind_mon.valid && kind_mon.ready) begin
        if (expected_kinds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch %0d: result beat with no token pending, token_kind %0d",
                     mismatches, kind_mon.token_kind);
          end
        end else begin
          want = expected_kinds.pop_front();
          tokens_checked++;
          if (want != KIND_INVALID) keyword_hits++;
          if (kind_mon.token_kind !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch %0d: token_kind expected %0d (%s) got %0d",
                       mismatches, want, want.name(), kind_mon.token_kind);
            end
          end
        end
      end

      // Character beats update the hash, the stored prefix and the length.
      if (char_mon.valid && char_mon.ready) begin
        hash_run = hash_run * HASH_W'(31) + HASH_W'(char_mon.char_code);
        if (token_len < MAX_KEYWORD_LEN) token_chars[token_len] = char_mon.char_code;
        if (token_len <= MAX_KEYWORD_LEN) token_len++;
        if (char_mon.token_end) begin
          expected_kinds.push_back(classify_token());
          hash_run  = HASH_SEED;
          token_len = 0;
        end
      end
    end
    pending <= expected_kinds.size();
  end

endmodule

// ----- tb/sv/tb_keyword_token_classifier_top.sv -----
// ----------------------------------------------------------------------------
// Keyword token classifier testbench
// Sends every keyword, then random keyword, near-miss, long and arbitrary tokens
// under three idle patterns and one long result stall; a checker beside the block
// predicts each token kind and compares the result beats.
// ----------------------------------------------------------------------------
module tb_keyword_token_classifier_top;
  import ktc_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  ktc_char_if char_bus ();
  ktc_kind_if kind_bus ();

  keyword_token_classifier_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_bus),
    .out_ch (kind_bus)
  );

  int mismatches;
  int pending;
  int tokens_checked;
  int keyword_hits;

  keyword_kind_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .char_mon       (char_bus),
    .kind_mon       (kind_bus),
    .mismatches     (mismatches),
    .pending        (pending),
    .tokens_checked (tokens_checked),
    .keyword_hits   (keyword_hits)
  );

  int    phase       = 0;
  int    tx_idle_pct = 27;
  int    rx_idle_pct = 47;
  int    chars_sent  = 0;
  char_t token_buf [$];

  // Load the characters of keyword k into the token buffer.
  function automatic void load_keyword(input int k);
    logic [31:0] text;
    int          len;
    case (k)
      0: begin text = "+";    len = 1; end
      1: begin text = "-";    len = 1; end
      2: begin text = "*";    len = 1; end
      3: begin text = "/";    len = 1; end
      4: begin text = "swap"; len = 4; end
      5: begin text = "rot";  len = 3; end
      6: begin text = "pop";  len = 3; end
      7: begin text = "dup";  len = 3; end
      8: begin text = "drop"; len = 4; end
      default: begin text = "nip"; len = 3; end
    endcase
    token_buf.delete();
    for (int i = 0; i < len; i++) token_buf.push_back(text[8*(len-1-i) +: 8]);
  endfunction

  // Half the time a lower-case letter, otherwise any byte.
  function automatic char_t random_char();
    if ($urandom_range(1) == 1) return char_t'($urandom_range(8'h7A, 8'h61));
    return char_t'($urandom_range(255));
  endfunction

  // Mostly keywords and near misses, the rest arbitrary or overlong tokens.
  function automatic void make_random_token();
    int pick;
    int pos;
    pick = $urandom_range(99);
    load_keyword($urandom_range(KW_COUNT - 1));
    if (pick < 45) begin
      // exact keyword
    end else if (pick < 60) begin
      pos = $urandom_range(token_buf.size() - 1);
      token_buf[pos] = random_char();
    end else if (pick < 70) begin
      if (token_buf.size() > 1) begin
        void'(token_buf.pop_back());
      end else begin
        token_buf[0] = token_buf[0] ^ char_t'(1 << $urandom_range(7));
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(6, 1)) token_buf.push_back(random_char());
    end else begin
      token_buf.delete();
      repeat ($urandom_range(12, 1)) token_buf.push_back(random_char());
    end
  endfunction

  // One character beat, with random idle cycles in front of it.
  task automatic send_char(input char_t c, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.token_end <= last;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_token();
    for (int i = 0; i < token_buf.size(); i++) begin
      send_char(token_buf[i], i == token_buf.size() - 1);
    end
  endtask

  // Result side: random stalls, plus one long hold-off when the last phase
  // starts so that the block fills up while characters keep coming.
  initial begin : result_receiver
    int hold_left;
    bit hold_done;
    hold_left      = 0;
    hold_done      = 1'b0;
    kind_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        kind_bus.ready <= 1'b0;
      end else begin
        kind_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(200_000 * 20);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    char_bus.token_end = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Every keyword once, then the extreme single-character tokens.
    for (int k = 0; k < KW_COUNT; k++) begin
      load_keyword(k);
      send_token();
    end
    token_buf = '{8'hFF};
    send_token();
    token_buf = '{8'h00};
    send_token();

    while (chars_sent < 500) begin
      make_random_token();
      send_token();
    end

    phase       <= 1;
    tx_idle_pct  = 47;
    rx_idle_pct <= 27;
    while (chars_sent < 1000) begin
      make_random_token();
      send_token();
    end

    phase       <= 2;
    tx_idle_pct  = 0;
    rx_idle_pct <= 0;
    while (chars_sent < 1500) begin
      make_random_token();
      send_token();
    end

    // Drain the outstanding results, then allow for the block's latency.
    char_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d characters in %0d tokens, %0d of them keywords,",
             chars_sent, tokens_checked, keyword_hits);
    $display("under three idle patterns and one long result hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
